// File: design/ir_serial_key_frame_classifier_macros.svh
// Assertion macros used by the frame classifier core
`ifndef IR_SERIAL_KEY_FRAME_CLASSIFIER_MACROS_SVH
`define IR_SERIAL_KEY_FRAME_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SKFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skfc assertion failed");

// Next-cycle implication
`define SKFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skfc assertion failed");

`else

`define SKFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SKFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/skfc_pkg.sv
package skfc_pkg;

    // Frame length limit and number of bytes kept per frame
    localparam int MAX_FRAME_BYTES_DEF = 16;
    localparam int KEEP_BYTES          = 8;

    // Header bytes of a valid key frame
    localparam logic [7:0] HDR0 = 8'h90;
    localparam logic [7:0] HDR1 = 8'h46;
    localparam logic [7:0] HDR2 = 8'h42;

    // Reset value of the repeat window register
    localparam logic [7:0] REPEAT_WINDOW_RST = 8'd2;

    // Register index of the repeat window
    localparam logic REG_REPEAT_WINDOW = 1'b0;

    // Input function codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_GAP  = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_REPEAT  = 3'd1;
    localparam logic [2:0] ST_REP_REJ = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_JAM     = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        logic [31:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] key_code;
    } out_item_t;

endpackage

// File: design/ir_serial_key_frame_classifier.sv
// The result of the item that ends a frame passes through the input register and then the
// result register, from which it is taken.
// Throughput: one item per cycle while the result is not stalled; the frame state updates once per item in one pass.
// A stalled result holds the core; the input register keeps one item meanwhile.
// Reset (rst_n, asynchronous, active low) clears the frame state, last key code,
// both timestamps and the pipeline valids; the repeat window returns to 2.
module ir_serial_key_frame_classifier
#(
    parameter int MAX_FRAME_BYTES = skfc_pkg::MAX_FRAME_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  skfc_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output skfc_pkg::out_item_t result_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import skfc_pkg::*;

    logic       window_sel;
    logic [7:0] repeat_window_reg;
    logic [7:0] repeat_window_next;
    logic       cfg_wr;
    logic       item_valid;
    in_item_t   item;
    logic       advance;

    // Decode register writes
    assign pready = 1'b1;
    assign window_sel = (paddr[2] == REG_REPEAT_WINDOW);
    assign cfg_wr = psel && penable && pwrite && pready && window_sel;

    always_comb
    begin
        repeat_window_next = repeat_window_reg;
        if (cfg_wr)
        begin
            repeat_window_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_window_reg <= REPEAT_WINDOW_RST;
        end
        else
        begin
            repeat_window_reg <= repeat_window_next;
        end
    end

    // Read back the register
    assign prdata = window_sel ? {24'd0, repeat_window_reg} : 32'd0;

    skfc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    skfc_core #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .advance       (advance),
        .repeat_window (repeat_window_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_item   (result_item)
    );

endmodule

// File: design/skfc_in_stage.sv
module skfc_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  skfc_pkg::in_item_t byte_item,
    input  logic               advance,
    output logic               item_valid,
    output skfc_pkg::in_item_t item
);
    import skfc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // Take a new item when the register is empty or its item moves on
    assign byte_stall = valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload of the item
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/skfc_core.sv
module skfc_core
#(
    parameter int MAX_FRAME_BYTES = skfc_pkg::MAX_FRAME_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  skfc_pkg::in_item_t  item,
    output logic                advance,
    input  logic [7:0]          repeat_window,
    output logic                result_valid,
    input  logic                result_stall,
    output skfc_pkg::out_item_t result_item
);
    import skfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_KEEP = CNT_W'(KEEP_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             az_reg, az_next;
    logic [63:0]      last_reg, last_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      prev_reg, prev_next;
    logic [7:0]       frame_reg [KEEP_BYTES];
    logic             res_valid_reg, res_valid_next;
    out_item_t        res_reg;

    logic [7:0]       bytes_byte [KEEP_BYTES];
    logic [7:0]       bytes_cls [KEEP_BYTES];
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] n_cls;
    logic             az_byte;
    logic             az_cls;
    logic             is_gap;
    logic             frame_end;
    logic             load_res;
    logic [31:0]      diff;
    logic [63:0]      packed_code;
    out_item_t        cls;

    // Advance when the result register is free or being drained
    assign advance  = item_valid && (!res_valid_reg || !result_stall);
    assign is_gap   = (item.func == FUNC_GAP);
    assign cnt_inc  = count_reg + CNT_ONE;

    // Merge the incoming byte into the kept bytes
    always_comb
    begin
        for (int k = 0; k < KEEP_BYTES; k++)
        begin
            bytes_byte[k] = frame_reg[k];
            if (count_reg == CNT_W'(k))
            begin
                bytes_byte[k] = item.rx_byte;
            end
        end
    end

    assign az_byte   = az_reg && (item.rx_byte == 8'd0);
    assign frame_end = is_gap ? (count_reg != '0) : (cnt_inc == CNT_MAX);
    assign load_res  = advance && frame_end;

    // Select the frame view that is classified
    always_comb
    begin
        for (int k = 0; k < KEEP_BYTES; k++)
        begin
            bytes_cls[k] = is_gap ? frame_reg[k] : bytes_byte[k];
        end
    end

    assign n_cls  = is_gap ? count_reg : cnt_inc;
    assign az_cls = is_gap ? az_reg : az_byte;
    assign diff   = start_reg - prev_reg;

    // Pack the kept bytes big-endian
    always_comb
    begin
        packed_code = '0;
        for (int k = 0; k < KEEP_BYTES; k++)
        begin
            packed_code = {packed_code[55:0], bytes_cls[k]};
        end
    end

    // Classify the finished frame
    always_comb
    begin
        cls.status   = ST_INVALID;
        cls.key_code = '0;
        if (n_cls == CNT_ONE && bytes_cls[0] == 8'd0)
        begin
            if (last_reg != '0 && diff < {24'd0, repeat_window})
            begin
                cls.status   = ST_REPEAT;
                cls.key_code = last_reg;
            end
            else
            begin
                cls.status = ST_REP_REJ;
            end
        end
        else if (n_cls < CNT_KEEP)
        begin
            cls.status = ST_SHORT;
        end
        else if (bytes_cls[0] == HDR0 && bytes_cls[1] == HDR1 && bytes_cls[2] == HDR2)
        begin
            cls.status   = ST_NEW;
            cls.key_code = packed_code;
        end
        else if (n_cls == CNT_MAX && az_cls)
        begin
            cls.status = ST_JAM;
        end
        else
        begin
            cls.status = ST_INVALID;
        end
    end

    // Next frame state
    always_comb
    begin
        count_next = count_reg;
        az_next    = az_reg;
        last_next  = last_reg;
        start_next = start_reg;
        prev_next  = prev_reg;
        if (advance)
        begin
            if (!is_gap)
            begin
                if (count_reg == '0)
                begin
                    start_next = item.now_seconds;
                end
                count_next = cnt_inc;
                az_next    = az_byte;
            end
            if (frame_end)
            begin
                count_next = '0;
                az_next    = 1'b1;
                prev_next  = item.now_seconds;
                if (cls.status == ST_NEW)
                begin
                    last_next = cls.key_code;
                end
                else if (cls.status != ST_REPEAT)
                begin
                    last_next = '0;
                end
            end
        end
    end

    // Next result valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = frame_end;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            az_reg        <= 1'b1;
            last_reg      <= '0;
            start_reg     <= '0;
            prev_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            az_reg        <= az_next;
            last_reg      <= last_next;
            start_reg     <= start_next;
            prev_reg      <= prev_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Store kept bytes of the frame
    always_ff @(posedge clk)
    begin
        if (advance && !is_gap)
        begin
            for (int k = 0; k < KEEP_BYTES; k++)
            begin
                frame_reg[k] <= bytes_byte[k];
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= cls;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_reg;

    `include "ir_serial_key_frame_classifier_macros.svh"

    `SKFC_ASSERT_NEXT(a_count_clear, clk, rst_n, load_res, count_reg == '0 && az_reg)
    `SKFC_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg < CNT_MAX)
    `SKFC_ASSERT_IMPL(a_empty_gap, clk, rst_n, advance && is_gap && count_reg == '0, !load_res)
    `SKFC_ASSERT_IMPL(a_code_zero, clk, rst_n,
        res_valid_reg && res_reg.status != ST_NEW && res_reg.status != ST_REPEAT,
        res_reg.key_code == '0)

endmodule
